// File: rtl/core/sar_pkg.sv
// Shared types and constants for the spiral angle rotation block.
// Holds the CORDIC arctangent table and fixed-point formats; no dependencies.
package sar_pkg;

  localparam int CORDIC_STAGES = 18;
  localparam int FRAC_BITS     = 16;
  localparam int ANG_FRAC      = 24;
  localparam int TRIG_FRAC     = 30;
  localparam int VW            = 60;  // vector width, u1/u2 below 2^56 plus growth
  localparam int ZW            = 36;  // angle accumulator width
  localparam int RW            = 34;  // rotation vector width
  localparam logic signed [RW-1:0] INV_GAIN = 34'sd652032874;

  localparam logic [2:0] REG_COEF_A   = 3'd0;
  localparam logic [2:0] REG_COEF_B   = 3'd1;
  localparam logic [2:0] REG_COEF_C   = 3'd2;
  localparam logic [2:0] REG_COEF_D   = 3'd3;
  localparam logic [2:0] REG_CENTRE_X = 3'd4;
  localparam logic [2:0] REG_CENTRE_Y = 3'd5;

  typedef struct packed {
    logic signed [23:0] a;
    logic signed [23:0] b;
    logic signed [23:0] c;
    logic signed [23:0] d;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } cfg_t;

  // one item inside the CORDIC pipe
  typedef struct packed {
    logic                 zero;
    logic [1:0]           quad;  // 0 none, 1 turned -90, 2 turned +90
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [ZW-1:0] z;
    logic signed [RW-1:0] rc;
    logic signed [RW-1:0] rs;
  } cord_t;

  localparam logic [1:0] QUAD_NONE = 2'd0;
  localparam logic [1:0] QUAD_POS  = 2'd1;
  localparam logic [1:0] QUAD_NEG  = 2'd2;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    begin
      case (i)
        5'd0: r = 36'sd754974720;  5'd1: r = 36'sd445687602;
        5'd2: r = 36'sd235489088;  5'd3: r = 36'sd119537938;
        5'd4: r = 36'sd60000934;   5'd5: r = 36'sd30029717;
        5'd6: r = 36'sd15018523;   5'd7: r = 36'sd7509720;
        5'd8: r = 36'sd3754917;    5'd9: r = 36'sd1877466;
        5'd10: r = 36'sd938734;    5'd11: r = 36'sd469367;
        5'd12: r = 36'sd234684;    5'd13: r = 36'sd117342;
        5'd14: r = 36'sd58671;     5'd15: r = 36'sd29335;
        5'd16: r = 36'sd14668;     5'd17: r = 36'sd7334;
        5'd18: r = 36'sd3667;      5'd19: r = 36'sd1833;
        5'd20: r = 36'sd917;       5'd21: r = 36'sd458;
        5'd22: r = 36'sd229;       5'd23: r = 36'sd115;
        5'd24: r = 36'sd57;        5'd25: r = 36'sd29;
        5'd26: r = 36'sd14;        5'd27: r = 36'sd7;
        5'd28: r = 36'sd4;         5'd29: r = 36'sd2;
        5'd30: r = 36'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: rtl/core/spiral_angle_rotation.sv
// Top level of the spiral angle rotation block: config registers, front end,
// CORDIC stage chain, output rounding and output register. Uses sar_pkg.
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | in_point_x, in_point_y
//  out     | out_valid/ out_ready | out_angle_deg, out_rot_cos, out_rot_sin
//  cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; an item passes the front-end
// register stages, the CORDIC_STAGES iteration stages and the output register.
// The whole pipe advances when the output register is empty or taken; a stall
// freezes every stage. Reset clears valid bits and config registers.
module spiral_angle_rotation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [24:0] out_angle_deg,
  output logic signed [17:0] out_rot_cos,
  output logic signed [17:0] out_rot_sin,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int N = sar_pkg::CORDIC_STAGES;
  localparam int ASH = sar_pkg::ANG_FRAC - sar_pkg::FRAC_BITS;
  localparam int TSH = sar_pkg::TRIG_FRAC - sar_pkg::FRAC_BITS;
  localparam logic signed [sar_pkg::ZW-1:0] ALIM = sar_pkg::ZW'(180) <<< sar_pkg::FRAC_BITS;
  localparam logic signed [sar_pkg::RW-1:0] ONE = sar_pkg::RW'(1) <<< sar_pkg::FRAC_BITS;

  sar_pkg::cfg_t  cfg_r;
  logic           en;
  logic           ov_r;
  logic           sv [0:N];
  sar_pkg::cord_t sd [0:N];
  logic signed [24:0] ang_r, ang_nxt;
  logic signed [17:0] cos_r, cos_nxt, sin_r, sin_nxt;
  logic signed [sar_pkg::ZW-1:0] za;
  logic signed [sar_pkg::RW-1:0] rc, rs, rcr, rsr, sn;

  assign en        = !ov_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sar_pkg::REG_COEF_A:   cfg_r.a  <= cfg_data[23:0];
        sar_pkg::REG_COEF_B:   cfg_r.b  <= cfg_data[23:0];
        sar_pkg::REG_COEF_C:   cfg_r.c  <= cfg_data[23:0];
        sar_pkg::REG_COEF_D:   cfg_r.d  <= cfg_data[23:0];
        sar_pkg::REG_CENTRE_X: cfg_r.cx <= cfg_data;
        sar_pkg::REG_CENTRE_Y: cfg_r.cy <= cfg_data;
        default: ;
      endcase
    end
  end

  sar_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .cfg(cfg_r),
    .in_v(in_valid), .px(in_point_x), .py(in_point_y),
    .out_v(sv[0]), .out_d(sd[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_stage
    sar_cordic_stage u_stage (
      .clk(clk), .rst_n(rst_n), .en(en), .idx(5'(g)),
      .in_v(sv[g]), .in_d(sd[g]), .out_v(sv[g+1]), .out_d(sd[g+1])
    );
  end

  always_comb begin
    // undo the quadrant fold on the rotation vector
    rc = sd[N].rc;
    rs = sd[N].rs;
    if (sd[N].quad == sar_pkg::QUAD_POS) begin
      rc = -sd[N].rs; rs = sd[N].rc;
    end else if (sd[N].quad == sar_pkg::QUAD_NEG) begin
      rc = sd[N].rs;  rs = -sd[N].rc;
    end
    za  = (-sd[N].z + (sar_pkg::ZW'(1) <<< (ASH - 1))) >>> ASH;
    rcr = (rc + (sar_pkg::RW'(1) <<< (TSH - 1))) >>> TSH;
    rsr = (rs + (sar_pkg::RW'(1) <<< (TSH - 1))) >>> TSH;
    sn  = -rsr;
    if (za > ALIM) za = ALIM; else if (za < -ALIM) za = -ALIM;
    if (rcr > ONE) rcr = ONE; else if (rcr < -ONE) rcr = -ONE;
    if (sn > ONE) sn = ONE; else if (sn < -ONE) sn = -ONE;
    ang_nxt = za[24:0];
    cos_nxt = rcr[17:0];
    sin_nxt = sn[17:0];
    if (sd[N].zero) begin
      ang_nxt = '0;
      cos_nxt = ONE[17:0];
      sin_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= sv[N];
    if (en) begin
      ang_r <= ang_nxt; cos_r <= cos_nxt; sin_r <= sin_nxt;
    end
  end

  assign out_valid     = ov_r;
  assign out_angle_deg = ang_r;
  assign out_rot_cos   = cos_r;
  assign out_rot_sin   = sin_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_angle_deg))
    else $error("output item changed under stall");
  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rot_cos <= $signed(ONE[17:0]) && out_rot_cos >= -$signed(ONE[17:0]))
    else $error("cosine out of range");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("pipe stalled with empty output");
endmodule

// File: rtl/core/sar_front.sv
// Front end: centre subtraction, four products, sums and quadrant fold.
// Three register stages; uses sar_pkg.
module sar_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  sar_pkg::cfg_t               cfg,
  input  logic                        in_v,
  input  logic signed [31:0]          px,
  input  logic signed [31:0]          py,
  output logic                        out_v,
  output sar_pkg::cord_t              out_d
);
  logic               v0_r, v1_r, v2_r;
  logic signed [32:0] x_r, y_r;
  logic signed [56:0] pa_r, pb_r, pc_r, pd_r;
  sar_pkg::cord_t     d2_r;
  sar_pkg::cord_t     d2_nxt;
  logic signed [sar_pkg::VW-1:0] u1, u2;

  assign u1 = sar_pkg::VW'(pa_r) + sar_pkg::VW'(pb_r);
  assign u2 = sar_pkg::VW'(pc_r) + sar_pkg::VW'(pd_r);

  always_comb begin
    d2_nxt      = '0;
    d2_nxt.zero = (u1 == '0) && (u2 == '0);
    d2_nxt.rc   = sar_pkg::INV_GAIN;
    d2_nxt.vx   = u2;
    d2_nxt.vy   = u1;
    d2_nxt.quad = sar_pkg::QUAD_NONE;
    if (u2 < 0) begin
      if (u1 >= 0) begin
        d2_nxt.vx   = u1;
        d2_nxt.vy   = -u2;
        d2_nxt.quad = sar_pkg::QUAD_POS;
        d2_nxt.z    = sar_pkg::ZW'(90) <<< sar_pkg::ANG_FRAC;
      end else begin
        d2_nxt.vx   = -u1;
        d2_nxt.vy   = u2;
        d2_nxt.quad = sar_pkg::QUAD_NEG;
        d2_nxt.z    = -(sar_pkg::ZW'(90) <<< sar_pkg::ANG_FRAC);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_v; v1_r <= v0_r; v2_r <= v1_r;
    end
    if (en) begin
      x_r  <= 33'(px) - 33'(cfg.cx);
      y_r  <= 33'(py) - 33'(cfg.cy);
      pa_r <= 57'(cfg.a) * 57'(x_r);
      pb_r <= 57'(cfg.b) * 57'(y_r);
      pc_r <= 57'(cfg.c) * 57'(x_r);
      pd_r <= 57'(cfg.d) * 57'(y_r);
      d2_r <= d2_nxt;
    end
  end

  assign out_v = v2_r;
  assign out_d = d2_r;
endmodule

// File: rtl/core/sar_cordic_stage.sv
// One CORDIC iteration: vectoring step and replayed rotation step, registered.
// Uses sar_pkg.
module sar_cordic_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [4:0]     idx,
  input  logic           in_v,
  input  sar_pkg::cord_t in_d,
  output logic           out_v,
  output sar_pkg::cord_t out_d
);
  logic           v_r;
  sar_pkg::cord_t d_r;
  sar_pkg::cord_t d_nxt;
  logic           dir;

  assign dir = (in_d.vy >= 0);

  always_comb begin
    d_nxt = in_d;
    if (dir) begin
      d_nxt.vx = in_d.vx + (in_d.vy >>> idx);
      d_nxt.vy = in_d.vy - (in_d.vx >>> idx);
      d_nxt.z  = in_d.z + sar_pkg::atan_deg(idx);
      d_nxt.rc = in_d.rc - (in_d.rs >>> idx);
      d_nxt.rs = in_d.rs + (in_d.rc >>> idx);
    end else begin
      d_nxt.vx = in_d.vx - (in_d.vy >>> idx);
      d_nxt.vy = in_d.vy + (in_d.vx >>> idx);
      d_nxt.z  = in_d.z - sar_pkg::atan_deg(idx);
      d_nxt.rc = in_d.rc + (in_d.rs >>> idx);
      d_nxt.rs = in_d.rs - (in_d.rc >>> idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (en) v_r <= in_v;
    if (en) d_r <= d_nxt;
  end

  assign out_v = v_r;
  assign out_d = d_r;
endmodule

// File: dv/spiral_angle_rotation_tb.sv
// Testbench for spiral_angle_rotation: drives Q16.16 points and register writes,
// predicts angle, cosine and sine with its own CORDIC model. Depends on sar_pkg.
`timescale 1ns / 1ps

module spiral_angle_rotation_tb;

  localparam int LATENCY = 22;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [24:0] angle;
    logic [17:0] cosv;
    logic [17:0] sinv;
  } rotation_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_point_x;
  logic signed [31:0] in_point_y;
  logic               out_valid;
  logic               out_ready;
  logic signed [24:0] out_angle_deg;
  logic signed [17:0] out_rot_cos;
  logic signed [17:0] out_rot_sin;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  spiral_angle_rotation uut (.*);

  // predictor copy of the registers
  logic signed [23:0] w_a, w_b, w_c, w_d;
  logic signed [31:0] ctr_x, ctr_y;

  rotation_t pending_rot[$];
  int  errors;
  bit  quiet;
  int  hold_ticket, hold_seen, hold_left, stall_left;

  longint atan_tab[18] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                           30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                           469367, 234684, 117342, 58671, 29335, 14668, 7334};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("spiral_angle_rotation_tb NOT OK");
    $finish;
  end

  function automatic longint clamp_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic rotation_t spiral_rotation(logic signed [31:0] px,
                                                logic signed [31:0] py);
    rotation_t r;
    longint xx, yy, u1, u2, vx, vy, z, t, rc, rs, dx, dy;
    int quad;
    bit turn[18];
    xx = longint'(px) - longint'(ctr_x);
    yy = longint'(py) - longint'(ctr_y);
    u1 = longint'(w_a) * xx + longint'(w_b) * yy;
    u2 = longint'(w_c) * xx + longint'(w_d) * yy;
    if (u1 == 0 && u2 == 0) begin
      r.angle = '0;
      r.cosv = 18'd65536;
      r.sinv = '0;
      return r;
    end
    vx = u2; vy = u1; z = 0; quad = 0;
    // fold the left half plane into the right one
    if (vx < 0) begin
      if (vy >= 0) begin
        t = vx; vx = vy; vy = -t; quad = 1; z = 64'sd90 <<< 24;
      end else begin
        t = vx; vx = -vy; vy = t; quad = -1; z = -(64'sd90 <<< 24);
      end
    end
    for (int i = 0; i < 18; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      turn[i] = (vy >= 0);
      if (turn[i]) begin
        vx += dx; vy -= dy; z += atan_tab[i];
      end else begin
        vx -= dx; vy += dy; z -= atan_tab[i];
      end
    end
    rc = 652032874;
    rs = 0;
    for (int i = 0; i < 18; i++) begin
      dx = rs >>> i;
      dy = rc >>> i;
      if (turn[i]) begin
        rc -= dx; rs += dy;
      end else begin
        rc += dx; rs -= dy;
      end
    end
    if (quad == 1) begin
      t = rc; rc = -rs; rs = t;
    end else if (quad == -1) begin
      t = rc; rc = rs; rs = -t;
    end
    r.angle = 25'(clamp_to(((-z) + 128) >>> 8, 64'sd180 <<< 16));
    r.cosv = 18'(clamp_to((rc + 8192) >>> 14, 65536));
    r.sinv = 18'(clamp_to(-((rs + 8192) >>> 14), 65536));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    rotation_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rot.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        e = pending_rot.pop_front();
        if (out_angle_deg !== e.angle)
          report_mismatch("angle_deg", out_angle_deg, $signed(e.angle));
        if (out_rot_cos !== e.cosv)
          report_mismatch("rot_cos", out_rot_cos, $signed(e.cosv));
        if (out_rot_sin !== e.sinv)
          report_mismatch("rot_sin", out_rot_sin, $signed(e.sinv));
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_rot.push_back(spiral_rotation(px, py));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_rot.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      sar_pkg::REG_COEF_A:   w_a = val[23:0];
      sar_pkg::REG_COEF_B:   w_b = val[23:0];
      sar_pkg::REG_COEF_C:   w_c = val[23:0];
      sar_pkg::REG_COEF_D:   w_d = val[23:0];
      sar_pkg::REG_CENTRE_X: ctr_x = val;
      sar_pkg::REG_CENTRE_Y: ctr_y = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] d, logic [31:0] cx, logic [31:0] cy);
    wait_idle();
    write_reg(sar_pkg::REG_COEF_A, a);
    write_reg(sar_pkg::REG_COEF_B, b);
    write_reg(sar_pkg::REG_COEF_C, c);
    write_reg(sar_pkg::REG_COEF_D, d);
    write_reg(sar_pkg::REG_CENTRE_X, cx);
    write_reg(sar_pkg::REG_CENTRE_Y, cy);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return 32'h0080_0000;
      1: return 32'h007f_ffff;
      2: return 32'h0000_0000;
      3: return $urandom_range(0, 131072) - 65536;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_defaults();
    // all coefficients zero: every point is a zero vector
    send_point(32'sh7fff_ffff, 32'sh8000_0000);
    send_point(32'sh0001_0000, -32'sh0001_0000);
    send_point('0, '0);
  endtask

  task automatic test_directed();
    // u1 = y, u2 = x: the angle is -atan2(y, x)
    write_all(32'h0, 32'h1_0000, 32'h1_0000, 32'h0, 32'h0, 32'h0);
    send_point(32'sh1_0000, 0);
    send_point(0, 32'sh1_0000);
    send_point(-32'sh1_0000, 0);  // on the negative axis: -180
    send_point(0, -32'sh1_0000);
    send_point(-32'sh1_0000, -32'sh1_0000);
    send_point(-32'sh1_0000, 32'sh1_0000);
    send_point(32'sh1_0000, 32'sh1_0000);
    send_point(0, 0);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh8000_0000, 32'sh7fff_ffff);
    send_point(1, -1);
    // extreme coefficients and centre
    write_all(32'h0080_0000, 32'h007f_ffff, 32'h007f_ffff, 32'h0080_0000,
              32'h7fff_ffff, 32'h8000_0000);
    send_point(32'sh8000_0000, 32'sh7fff_ffff);
    send_point(32'sh7fff_ffff, 32'sh8000_0000);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    write_all(32'h0080_0000, 32'h0080_0000, 32'h0080_0000, 32'h0080_0000,
              32'h8000_0000, 32'h7fff_ffff);
    send_point(32'sh7fff_ffff, 32'sh8000_0000);
    send_point(32'sh8000_0000, 32'sh7fff_ffff);
    send_point(0, 0);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 8; ph++) begin
      write_all(rand_coef(), rand_coef(), rand_coef(), rand_coef(), $urandom, $urandom);
      for (int n = 0; n < 140; n++) begin
        if ($urandom_range(0, 9) == 0)
          send_point(ctr_x, ctr_y);  // lands on the centre
        else
          send_point($urandom, $urandom);
      end
    end
  endtask

  task automatic test_backpressure();
    write_all(rand_coef(), rand_coef(), rand_coef(), rand_coef(), $urandom, $urandom);
    hold_ticket++;
    for (int n = 0; n < 100; n++) send_point($urandom, $urandom);
  endtask

  task automatic test_streaming();
    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    quiet = 1'b1;
    for (int n = 0; n < 60; n++) send_point($urandom, $urandom);
    write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    for (int n = 0; n < 20; n++) send_point($urandom, $urandom);
  endtask

  initial begin
    errors = 0;
    quiet = 1'b0;
    hold_ticket = 0;
    hold_seen = 0;
    hold_left = 0;
    stall_left = 0;
    w_a = '0; w_b = '0; w_c = '0; w_d = '0;
    ctr_x = '0; ctr_y = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_settings();
    test_backpressure();
    test_streaming();
    wait_idle();
    if (pending_rot.size() != 0) report_mismatch("items left over", pending_rot.size(), 0);
    if (errors == 0) begin
      $display("spiral_angle_rotation_tb OK");
    end else begin
      $display("spiral_angle_rotation_tb NOT OK");
    end
    $finish;
  end

endmodule
